FILE: rtl/dcb_pkg.sv
`default_nettype none

package dcb_pkg;

	localparam int COORD_BITS      = 10;
	localparam int PARAM_FRAC_BITS = 16;
	localparam int OUT_FRAC_BITS   = 8;
	localparam int NUM_REGS        = 8;
	localparam int NUM_POINTS      = 4;
	localparam int IDX_BITS        = $clog2(NUM_REGS);
	localparam int PARAM_BITS      = PARAM_FRAC_BITS + 1;
	localparam int FIX_BITS        = COORD_BITS + PARAM_FRAC_BITS;
	localparam int CURVE_BITS      = COORD_BITS + OUT_FRAC_BITS;
	localparam int PROD_BITS       = FIX_BITS + PARAM_BITS + 2;

	typedef logic [COORD_BITS-1:0] coord_t;
	typedef logic [PARAM_BITS-1:0] param_t;
	typedef logic [FIX_BITS-1:0]   fix_t;
	typedef logic [IDX_BITS-1:0]   idx_t;
	typedef logic [CURVE_BITS-1:0] curve_t;

	localparam param_t PARAM_ONE = {1'b1, {PARAM_FRAC_BITS{1'b0}}};

	localparam idx_t REG_P0_X = idx_t'(0);
	localparam idx_t REG_P0_Y = idx_t'(1);
	localparam idx_t REG_P1_X = idx_t'(2);
	localparam idx_t REG_P1_Y = idx_t'(3);
	localparam idx_t REG_P2_X = idx_t'(4);
	localparam idx_t REG_P2_Y = idx_t'(5);
	localparam idx_t REG_P3_X = idx_t'(6);
	localparam idx_t REG_P3_Y = idx_t'(7);

	typedef struct packed {
		coord_t [NUM_POINTS-1:0] x;
		coord_t [NUM_POINTS-1:0] y;
	} ctrl_pts_t;

	// ((1-t)a + t b) >> F  ==  a + floor(t (b - a) / 2^F)
	function automatic fix_t lerp(fix_t a, fix_t b, param_t t);
		logic signed [FIX_BITS:0]    d;
		logic signed [PROD_BITS-1:0] prod;
		logic signed [PROD_BITS-1:0] sum;
		d    = $signed({1'b0, b}) - $signed({1'b0, a});
		prod = $signed({1'b0, t}) * d;
		sum  = $signed({{(PROD_BITS-FIX_BITS){1'b0}}, a}) + (prod >>> PARAM_FRAC_BITS);
		return sum[FIX_BITS-1:0];
	endfunction

endpackage

`default_nettype wire

FILE: rtl/dcb_cfg_regs.sv
`default_nettype none

module dcb_cfg_regs (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  cfg_valid,
	input  wire                  cfg_ready,
	input  wire dcb_pkg::idx_t   cfg_index,
	input  wire dcb_pkg::coord_t cfg_data,
	output dcb_pkg::ctrl_pts_t   pts
);
	import dcb_pkg::*;

	ctrl_pts_t pts_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pts_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_P0_X: pts_q.x[0] <= cfg_data;
				REG_P0_Y: pts_q.y[0] <= cfg_data;
				REG_P1_X: pts_q.x[1] <= cfg_data;
				REG_P1_Y: pts_q.y[1] <= cfg_data;
				REG_P2_X: pts_q.x[2] <= cfg_data;
				REG_P2_Y: pts_q.y[2] <= cfg_data;
				REG_P3_X: pts_q.x[3] <= cfg_data;
				REG_P3_Y: pts_q.y[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	assign pts = pts_q;

endmodule

`default_nettype wire

FILE: rtl/dcb_lerp_pipe.sv
`default_nettype none

module dcb_lerp_pipe (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     in_valid,
	output logic                    in_ready,
	input  wire dcb_pkg::param_t    t_in,
	input  wire dcb_pkg::ctrl_pts_t pts,
	output logic                    out_valid,
	input  wire                     out_ready,
	output dcb_pkg::fix_t           fx,
	output dcb_pkg::fix_t           fy
);
	import dcb_pkg::*;

	param_t t_c;
	fix_t   p_c [2][NUM_POINTS];

	logic   v_s1, v_s2, v_s3;
	logic   en1, en2, en3;
	param_t t_s1, t_s2;
	fix_t   q_s1 [2][3];
	fix_t   r_s2 [2][2];
	fix_t   f_s3 [2];

	assign t_c = (t_in > PARAM_ONE) ? PARAM_ONE : t_in;

	always_comb begin
		for (int i = 0; i < NUM_POINTS; i++) begin
			p_c[0][i] = {pts.x[i], {PARAM_FRAC_BITS{1'b0}}};
			p_c[1][i] = {pts.y[i], {PARAM_FRAC_BITS{1'b0}}};
		end
	end

	// stage moves when empty or when the next one moves
	assign en3 = !v_s3 || out_ready;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && in_valid) begin
			t_s1 <= t_c;
			for (int a = 0; a < 2; a++)
				for (int k = 0; k < 3; k++)
					q_s1[a][k] <= lerp(p_c[a][k], p_c[a][k+1], t_c);
		end
		if (en2 && v_s1) begin
			t_s2 <= t_s1;
			for (int a = 0; a < 2; a++)
				for (int k = 0; k < 2; k++)
					r_s2[a][k] <= lerp(q_s1[a][k], q_s1[a][k+1], t_s1);
		end
		if (en3 && v_s2) begin
			for (int a = 0; a < 2; a++)
				f_s3[a] <= lerp(r_s2[a][0], r_s2[a][1], t_s2);
		end
	end

	assign in_ready  = en1;
	assign out_valid = v_s3;
	assign fx        = f_s3[0];
	assign fy        = f_s3[1];

endmodule

`default_nettype wire

FILE: rtl/de_casteljau_bezier_eval_core.sv
`default_nettype none

// Cubic Bezier evaluator (de Casteljau). Control points are written through the cfg port
// as integer pixels; each input word carries t in Q1.16 (values above 1.0 clamp to 1.0).
// Each result word gives the point in Q10.8 and its truncated pixel coordinates. One word
// is taken per cycle while the input is ready, and each passes a registered stage per lerp
// level; the cost is twelve 18x27 multipliers (three, two, one lerps per axis). Stalls
// on the output propagate back stage by stage, and empty stages keep filling meanwhile.
module de_casteljau_bezier_eval_core (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    in_valid,
	output logic                   in_ready,
	input  wire dcb_pkg::param_t   curve_param,
	output logic                   out_valid,
	input  wire                    out_ready,
	output dcb_pkg::curve_t        curve_x,
	output dcb_pkg::curve_t        curve_y,
	output dcb_pkg::coord_t        pixel_x,
	output dcb_pkg::coord_t        pixel_y,
	input  wire                    cfg_valid,
	output logic                   cfg_ready,
	input  wire dcb_pkg::idx_t     cfg_index,
	input  wire dcb_pkg::coord_t   cfg_data
);
	import dcb_pkg::*;

	ctrl_pts_t pts;
	fix_t      fx, fy;

	assign cfg_ready = 1'b1;

	dcb_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pts       (pts)
	);

	dcb_lerp_pipe u_pipe (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.t_in      (curve_param),
		.pts       (pts),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.fx        (fx),
		.fy        (fy)
	);

	assign curve_x = fx[FIX_BITS-1 -: CURVE_BITS];
	assign curve_y = fy[FIX_BITS-1 -: CURVE_BITS];
	assign pixel_x = fx[FIX_BITS-1 -: COORD_BITS];
	assign pixel_y = fy[FIX_BITS-1 -: COORD_BITS];

endmodule

`default_nettype wire

FILE: rtl/dcb_checker.sv
`default_nettype none

module dcb_checker (
	input wire                  clk,
	input wire                  arst_n,
	input wire                  in_valid,
	input wire                  in_ready,
	input wire                  out_valid,
	input wire                  out_ready,
	input wire dcb_pkg::curve_t curve_x,
	input wire dcb_pkg::curve_t curve_y,
	input wire dcb_pkg::coord_t pixel_x,
	input wire dcb_pkg::coord_t pixel_y
);
	import dcb_pkg::*;

	// stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(curve_x) && $stable(curve_y))
		else $error("stalled result word changed or dropped");

	// pixel fields are the integer part of the fixed-point fields
	a_pix_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pixel_x == curve_x[CURVE_BITS-1 -: COORD_BITS]
			&& pixel_y == curve_y[CURVE_BITS-1 -: COORD_BITS])
		else $error("pixel and curve fields disagree");

	// an empty or draining output stage never blocks the input
	a_no_block: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid || out_ready |-> in_ready)
		else $error("input stalled while output stage free");

	// nothing leaves an empty pipe
	a_no_ghost: assert property (@(posedge clk) disable iff (!arst_n)
		!in_valid ##1 !in_valid ##1 !in_valid ##1 1'b1 |-> !out_valid || $past(out_valid))
		else $error("result word appeared without input");

endmodule

bind de_casteljau_bezier_eval_core dcb_checker u_dcb_checker (.*);

`default_nettype wire
